[rtl/core/efd_pkg.sv]
// Package: widths, types and microcode table for the earliest-finish dispatcher.
`default_nettype none
package efd_pkg;

   localparam int MACHINES    = 32;
   localparam int ADDR_W      = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int IDX_W       = 5;
   localparam int PT_W        = 8;
   localparam int FT_W        = 16;
   localparam int SUM_W       = FT_W + 1;
   localparam int CNT_W       = 6;
   localparam int INDEX_LIMIT = 32;
   localparam int ACTIVE_MAX  = (MACHINES < INDEX_LIMIT) ? MACHINES : INDEX_LIMIT;

   localparam logic [SUM_W-1:0] NO_BEST    = '1;
   localparam logic [FT_W-1:0]  FINISH_MAX = '1;

   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_DISPATCH = 1'b1;

   typedef enum logic [2:0] {
      STEP_IDLE  = 3'd0,
      STEP_INIT  = 3'd1,
      STEP_SCAN  = 3'd2,
      STEP_EMIT  = 3'd3,
      STEP_LOAD  = 3'd4
   } step_type;

   typedef enum logic [2:0] {
      SEQ_NEXT   = 3'd0,
      SEQ_JUMP   = 3'd1,
      SEQ_ACCEPT = 3'd2,
      SEQ_SCAN   = 3'd3,
      SEQ_EMIT   = 3'd4
   } seq_type;

   typedef struct packed {
      logic     take;
      logic     rd_issue;
      logic     clr_best;
      logic     cmp_en;
      logic     ld_write;
      logic     emit;
      seq_type  seq;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              ld_en;
      logic [ADDR_W-1:0] ld_addr;
      logic [PT_W-1:0]   ld_time;
      logic              fin_en;
      logic [ADDR_W-1:0] fin_addr;
      logic [FT_W-1:0]   fin_time;
   } bank_ctrl_type;

   typedef struct packed {
      logic [PT_W-1:0] proc_time;
      logic [FT_W-1:0] finish_time;
   } bank_data_type;

   function automatic ctrl_type uc_rom(input step_type step);
      ctrl_type c;
      c = '{take: 1'b0, rd_issue: 1'b0, clr_best: 1'b0, cmp_en: 1'b0,
            ld_write: 1'b0, emit: 1'b0, seq: SEQ_JUMP, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            c.take   = 1'b1;
            c.seq    = SEQ_ACCEPT;
            c.target = STEP_LOAD;
         end
         STEP_INIT: begin
            c.rd_issue = 1'b1;
            c.clr_best = 1'b1;
            c.seq      = SEQ_NEXT;
         end
         STEP_SCAN: begin
            c.rd_issue = 1'b1;
            c.cmp_en   = 1'b1;
            c.seq      = SEQ_SCAN;
         end
         STEP_EMIT: begin
            c.emit   = 1'b1;
            c.seq    = SEQ_EMIT;
            c.target = STEP_IDLE;
         end
         STEP_LOAD: begin
            c.ld_write = 1'b1;
            c.seq      = SEQ_JUMP;
            c.target   = STEP_IDLE;
         end
         default: begin
            c.seq    = SEQ_JUMP;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

   function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] n;
      n = (count == '0) ? CNT_W'(1) : count;
      if (32'(n) > ACTIVE_MAX) begin
         n = CNT_W'(ACTIVE_MAX);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

[rtl/core/efd_machine_bank.sv]
// Machine bank: processing-time and finish-time memories with finish valid bits.
`default_nettype none
module efd_machine_bank (
   input  wire                   clock,
   input  wire                   reset,
   input  efd_pkg::bank_ctrl_type ctrl,
   output efd_pkg::bank_data_type rd_data
);

   logic [efd_pkg::PT_W-1:0] proc_mem [efd_pkg::MACHINES];
   logic [efd_pkg::FT_W-1:0] fin_mem  [efd_pkg::MACHINES];
   logic [efd_pkg::MACHINES-1:0] fin_valid_ff;
   logic [efd_pkg::MACHINES-1:0] fin_valid_in;

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (ctrl.ld_en) begin
         fin_valid_in[ctrl.ld_addr] = 1'b0;
      end
      if (ctrl.fin_en) begin
         fin_valid_in[ctrl.fin_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= '0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_en) begin
         proc_mem[ctrl.ld_addr] <= ctrl.ld_time;
      end
      if (ctrl.fin_en) begin
         fin_mem[ctrl.fin_addr] <= ctrl.fin_time;
      end
      if (ctrl.rd_en) begin
         rd_data.proc_time   <= proc_mem[ctrl.rd_addr];
         rd_data.finish_time <= fin_valid_ff[ctrl.rd_addr] ? fin_mem[ctrl.rd_addr] : '0;
      end
   end

endmodule
`default_nettype wire

[rtl/core/earliest_finish_dispatcher.sv]
// Top level: microcoded earliest-finish dispatcher over a bank of machines.
// Load: accepted in idle and written in the load step that follows, which returns to idle.
// Dispatch: accept, init, then a scan over the active machines through the single
// registered bank read port and one add-compare unit; emit registers the result and waits while the output is full.
// A new request is taken only in idle; the active machine count n is 1 to 32.
// Reset: synchronous; clears finish times (valid bits), count to 1, step and output valid.
`default_nettype none
module earliest_finish_dispatcher (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_mode,
   input  wire  [4:0] req_machine_index,
   input  wire  [7:0] req_proc_time,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [4:0] rsp_chosen_machine,
   output logic [15:0] rsp_finish_time,
   input  wire        csr_wr_en,
   input  wire  [5:0] csr_wr_data
);

   efd_pkg::step_type step_ff, step_in;
   efd_pkg::ctrl_type ctrl;

   logic [efd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [efd_pkg::CNT_W-1:0] active_n;
   logic [efd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [efd_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [efd_pkg::IDX_W-1:0] pick_ff, pick_in;
   logic [efd_pkg::SUM_W-1:0] best_ff, best_in;
   logic [efd_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [efd_pkg::PT_W-1:0]  pt_ff, pt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [efd_pkg::IDX_W-1:0] rsp_machine_ff, rsp_machine_in;
   logic [efd_pkg::FT_W-1:0]  rsp_time_ff, rsp_time_in;

   logic                      accept;
   logic                      scan_done;
   logic                      out_free;
   logic                      rd_en;
   logic [efd_pkg::IDX_W-1:0] rd_addr;
   logic [efd_pkg::SUM_W-1:0] sum;
   logic [efd_pkg::FT_W-1:0]  sat_best;

   efd_pkg::bank_ctrl_type bank_ctrl;
   efd_pkg::bank_data_type bank_data;

   efd_machine_bank u_bank (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (bank_ctrl),
      .rd_data (bank_data)
   );

   assign ctrl      = efd_pkg::uc_rom(step_ff);
   assign active_n  = efd_pkg::active_count(count_ff);
   assign req_ready = ctrl.take;
   assign accept    = req_valid && ctrl.take;
   assign scan_done = (cnt_ff == active_n);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sum       = efd_pkg::SUM_W'(bank_data.finish_time) +
                      efd_pkg::SUM_W'(bank_data.proc_time);
   assign sat_best  = best_ff[efd_pkg::SUM_W-1] ? efd_pkg::FINISH_MAX
                                                : best_ff[efd_pkg::FT_W-1:0];

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_machine = rsp_machine_ff;
   assign rsp_finish_time    = rsp_time_ff;

   always_comb begin
      step_in        = step_ff;
      count_in       = csr_wr_en ? csr_wr_data : count_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      idx_in         = idx_ff;
      pt_in          = pt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_machine_in = rsp_machine_ff;
      rsp_time_in    = rsp_time_ff;
      bank_ctrl      = '0;

      if (accept) begin
         idx_in = req_machine_index;
         pt_in  = req_proc_time;
      end

      // issue one read a cycle; the init step restarts at machine zero
      rd_en   = ctrl.rd_issue && (ctrl.clr_best || !scan_done);
      rd_addr = ctrl.clr_best ? '0 : cnt_ff[efd_pkg::IDX_W-1:0];
      if (rd_en) begin
         cnt_in    = efd_pkg::CNT_W'(rd_addr) + efd_pkg::CNT_W'(1);
         rd_idx_in = rd_addr;
      end
      bank_ctrl.rd_en   = rd_en;
      bank_ctrl.rd_addr = efd_pkg::ADDR_W'(rd_addr);

      if (ctrl.clr_best) begin
         best_in = efd_pkg::NO_BEST;
         pick_in = '0;
      end
      if (ctrl.cmp_en && (sum < best_ff)) begin
         best_in = sum;
         pick_in = rd_idx_ff;
      end

      if (ctrl.ld_write && (32'(idx_ff) < efd_pkg::MACHINES)) begin
         bank_ctrl.ld_en   = 1'b1;
         bank_ctrl.ld_addr = efd_pkg::ADDR_W'(idx_ff);
         bank_ctrl.ld_time = pt_ff;
      end

      if (ctrl.emit && out_free) begin
         rsp_valid_in       = 1'b1;
         rsp_machine_in     = pick_ff;
         rsp_time_in        = sat_best;
         bank_ctrl.fin_en   = 1'b1;
         bank_ctrl.fin_addr = efd_pkg::ADDR_W'(pick_ff);
         bank_ctrl.fin_time = sat_best;
      end

      case (ctrl.seq)
         efd_pkg::SEQ_NEXT: begin
            step_in = efd_pkg::step_type'(step_ff + 3'd1);
         end
         efd_pkg::SEQ_JUMP: begin
            step_in = ctrl.target;
         end
         efd_pkg::SEQ_ACCEPT: begin
            if (accept) begin
               step_in = (req_mode == efd_pkg::MODE_DISPATCH)
                         ? efd_pkg::step_type'(step_ff + 3'd1) : ctrl.target;
            end
         end
         efd_pkg::SEQ_SCAN: begin
            if (scan_done) begin
               step_in = efd_pkg::step_type'(step_ff + 3'd1);
            end
         end
         efd_pkg::SEQ_EMIT: begin
            if (out_free) begin
               step_in = ctrl.target;
            end
         end
         default: begin
            step_in = efd_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= efd_pkg::STEP_IDLE;
         count_ff     <= efd_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      idx_ff         <= idx_in;
      pt_ff          <= pt_in;
      rsp_machine_ff <= rsp_machine_in;
      rsp_time_ff    <= rsp_time_in;
   end

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for the earliest-finish dispatcher: random load and dispatch beats with a predictor.
`default_nettype none
module testbench;

   localparam int   SETTLE_CYCLES = 40;
   localparam int   CYCLE_LIMIT   = 600000;
   localparam int   REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [4:0]  chosen_machine;
      logic [15:0] finish_time;
   } assignment_type;

   class dispatch_tracker;
      logic [7:0]  proc_time [efd_pkg::MACHINES];
      logic [15:0] finish_time [efd_pkg::MACHINES];
      bit          loaded [efd_pkg::MACHINES];
      logic [5:0]  machine_count;
      assignment_type expected_assignments [$];
      int          errors;

      function new();
         machine_count = 6'd1;
         errors = 0;
         for (int m = 0; m < efd_pkg::MACHINES; m++) begin
            proc_time[m]   = '0;
            finish_time[m] = '0;
            loaded[m]      = 1'b0;
         end
      endfunction

      function void set_count(logic [5:0] value);
         machine_count = value;
      endfunction

      function int unsigned active_span();
         int unsigned n;
         n = (machine_count == 6'd0) ? 1 : 32'(machine_count);
         if (n > efd_pkg::MACHINES) n = efd_pkg::MACHINES;
         if (n > efd_pkg::INDEX_LIMIT) n = efd_pkg::INDEX_LIMIT;
         return n;
      endfunction

      function int first_unloaded();
         for (int m = 0; m < int'(active_span()); m++) begin
            if (!loaded[m]) return m;
         end
         return -1;
      endfunction

      function int pending();
         return expected_assignments.size();
      endfunction

      function void note_item(logic mode, logic [4:0] idx, logic [7:0] pt);
         int unsigned best;
         int unsigned sum;
         int unsigned pick;
         assignment_type job;
         if (mode == efd_pkg::MODE_LOAD) begin
            if (32'(idx) < efd_pkg::MACHINES) begin
               proc_time[idx]   = pt;
               finish_time[idx] = '0;
               loaded[idx]      = 1'b1;
            end
            return;
         end
         best = 32'h7fff_ffff;
         pick = 0;
         for (int unsigned m = 0; m < active_span(); m++) begin
            sum = 32'(finish_time[m]) + 32'(proc_time[m]);
            if (sum < best) begin
               best = sum;
               pick = m;
            end
         end
         sum = 32'(finish_time[pick]) + 32'(proc_time[pick]);
         if (sum > 32'hffff) sum = 32'hffff;
         finish_time[pick]  = sum[15:0];
         job.chosen_machine = pick[4:0];
         job.finish_time    = sum[15:0];
         expected_assignments.push_back(job);
      endfunction

      function void check_assignment(logic [4:0] machine, logic [15:0] finish);
         assignment_type job;
         if (expected_assignments.size() == 0) begin
            if (errors < REPORT_LIMIT)
               $display("stray result beat: machine %0d finish %0d", machine, finish);
            errors++;
            return;
         end
         job = expected_assignments.pop_front();
         if (job.chosen_machine !== machine || job.finish_time !== finish) begin
            if (errors < REPORT_LIMIT)
               $display("dispatch: expected machine %0d finish %0d, got machine %0d finish %0d",
                        job.chosen_machine, job.finish_time, machine, finish);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic        req_mode = efd_pkg::MODE_LOAD;
   logic [4:0]  req_machine_index = '0;
   logic [7:0]  req_proc_time = '0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [4:0]  rsp_chosen_machine;
   wire  [15:0] rsp_finish_time;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;
   int              cycles = 0;
   dispatch_tracker sb;

   earliest_finish_dispatcher u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_machine_index  (req_machine_index),
      .req_proc_time      (req_proc_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chosen_machine (rsp_chosen_machine),
      .rsp_finish_time    (rsp_finish_time),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(input logic mode, input logic [4:0] idx, input logic [7:0] pt);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_machine_index <= idx;
      req_proc_time     <= pt;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_item(mode, idx, pt);
   endtask

   // drain outstanding results, then let a trailing load finish
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [5:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_count(value);
   endtask

   task automatic run_phase(input int items, input int dispatch_pct, input int pt_max);
      logic       mode;
      logic [4:0] idx;
      logic [7:0] pt;
      int         hole;
      int unsigned pick;
      for (int k = 0; k < items; k++) begin
         mode = ($urandom_range(0, 99) < dispatch_pct) ? efd_pkg::MODE_DISPATCH
                                                         : efd_pkg::MODE_LOAD;
         idx  = 5'($urandom_range(0, 31));
         pick = $urandom_range(0, 19);
         if (pick == 0) pt = 8'd0;
         else if (pick == 1) pt = 8'd255;
         else pt = 8'($urandom_range(1, pt_max));
         // fill any unloaded active machine before a dispatch
         if (mode == efd_pkg::MODE_DISPATCH) begin
            hole = sb.first_unloaded();
            if (hole >= 0) begin
               mode = efd_pkg::MODE_LOAD;
               idx  = 5'(hole);
            end
         end
         send_item(mode, idx, pt);
      end
   endtask

   initial begin
      @(posedge clock);
      forever begin
         int unsigned stall;
         stall = rsp_idle_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_assignment(rsp_chosen_machine, rsp_finish_time);
      end
   end

   initial begin
      int plan [15];
      plan = '{2, 63, 32, 1, 0, 17, 5, 33, 8, 3, 24, 12, 6, 31, 2};
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(efd_pkg::MODE_LOAD, 5'd0, 8'd0);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);
      send_item(efd_pkg::MODE_LOAD, 5'd0, 8'd255);
      send_item(efd_pkg::MODE_DISPATCH, 5'd31, 8'd255);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);
      send_item(efd_pkg::MODE_LOAD, 5'd31, 8'd255);
      send_item(efd_pkg::MODE_LOAD, 5'd1, 8'd1);
      send_item(efd_pkg::MODE_DISPATCH, 5'd1, 8'd1);
      write_count(6'd0);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);
      write_count(6'd2);
      send_item(efd_pkg::MODE_LOAD, 5'd0, 8'd3);
      send_item(efd_pkg::MODE_LOAD, 5'd1, 8'd3);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);
      send_item(efd_pkg::MODE_DISPATCH, 5'd0, 8'd0);

      // drive machine 0 into saturation
      write_count(6'd1);
      send_item(efd_pkg::MODE_LOAD, 5'd0, 8'd255);
      run_phase(270, 100, 255);

      foreach (plan[p]) begin
         write_count(6'(plan[p]));
         req_idle_on = (p % 3 != 2);
         rsp_idle_on = (p % 4 != 3);
         run_phase(85, 70, (p % 3 == 1) ? 3 : 255);
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
